FILE: hw/rtl/swlc_pkg.sv
`default_nettype none

package swlc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_HIT,
        S_CHK,
        S_EVICT,
        S_INS,
        S_DONE
    } t_state;

    // width of the eviction count in a result word
    localparam int CNT_W = 5;

    // capacity after reset, cut to the size width at the top level
    localparam logic [63:0] CAP_RESET = 64'd1048576;

endpackage

`default_nettype wire

FILE: hw/rtl/size_weighted_lru_cache.sv
`default_nettype none

// Size-aware LRU cache tag table. Each request word carries a key and an object
// byte size; one result word per request reports hit, stored, the number of
// entries evicted and the bytes in use afterwards. Key, size and age of every
// slot live in one RAM that a small sequencer walks one slot per cycle; valid
// bits and the used-byte count sit in flip-flops, so no clearing pass follows
// reset. One adder/subtractor is shared by the fit check, the eviction credit
// and the insert charge. The lookup walk stops at a hit, and a hit adds one
// age-update walk. A miss adds one check per eviction round, a walk to find
// each LRU entry and, if the object fits, an insert walk. The result is then
// handed to the output register. A new request word is taken only while the
// sequencer is idle; a finished result may wait in the output register
// meanwhile. The capacity register must be written through i_cfg_wen and
// i_cfg_wdata only while idle; the block itself does not enforce this.
module size_weighted_lru_cache
    import swlc_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 32,
    parameter int SIZE_BITS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // capacity register
    input  wire logic                 i_cfg_wen,
    input  wire logic [SIZE_BITS-1:0] i_cfg_wdata,
    // request stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // tdata: key, item_size
    input  wire logic [((KEY_BITS+SIZE_BITS+7)/8)*8-1:0] i_s_tdata,
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // tdata: hit, stored, evicted_count, used_bytes
    output logic [((CNT_W+2+SIZE_BITS+7)/8)*8-1:0] o_m_tdata
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int AGE_W  = IDX_W;
    localparam int WORD_W = KEY_BITS + SIZE_BITS + AGE_W;
    localparam int OUT_W  = CNT_W + 2 + SIZE_BITS;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // control state
    t_state                 r_state, n_state;
    logic [IDX_W:0]         r_ra, n_ra;
    logic                   r_dv, n_dv;
    logic [IDX_W-1:0]       r_pi, n_pi;
    logic [ENTRIES-1:0]     r_valid, n_valid;
    logic [IDX_W:0]         r_count, n_count;
    logic [SIZE_BITS-1:0]   r_bytes, n_bytes;
    logic [SIZE_BITS-1:0]   r_cap, n_cap;
    logic                   r_ovalid, n_ovalid;

    // payload state
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [SIZE_BITS-1:0]   r_size, n_size;
    logic [IDX_W-1:0]       r_hidx, n_hidx;
    logic [AGE_W-1:0]       r_hage, n_hage;
    logic [CNT_W-1:0]       r_evicted, n_evicted;
    logic                   r_hit, n_hit;
    logic                   r_stored, n_stored;
    logic                   r_last, n_last;
    logic                   r_placed, n_placed;
    logic                   r_o_hit, n_o_hit;
    logic                   r_o_stored, n_o_stored;
    logic [CNT_W-1:0]       r_o_evicted, n_o_evicted;
    logic [SIZE_BITS-1:0]   r_o_bytes, n_o_bytes;

    // slot RAM ports
    logic                   ram_wen;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;

    logic [KEY_BITS-1:0]    rd_key;
    logic [SIZE_BITS-1:0]   rd_size;
    logic [AGE_W-1:0]       rd_age;
    logic                   rd_vld;
    logic                   pass_last;
    logic                   scanning;
    logic                   scan_start;

    // shared add/subtract unit
    logic                   alu_sub;
    logic [SIZE_BITS-1:0]   alu_op;
    logic [SIZE_BITS:0]     alu_res;
    logic                   over_cap;
    logic                   size_fits;
    logic [AGE_W-1:0]       lru_age;

    swlc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_wen   (ram_wen),
        .i_waddr (r_pi),
        .i_wdata (ram_wdata),
        .i_raddr (r_ra[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // fields of the slot word read back
    assign rd_key    = ram_rdata[KEY_BITS-1:0];
    assign rd_size   = ram_rdata[KEY_BITS +: SIZE_BITS];
    assign rd_age    = ram_rdata[KEY_BITS+SIZE_BITS +: AGE_W];
    assign rd_vld    = r_valid[r_pi];
    assign pass_last = r_dv && (r_pi == IDX_W'(ENTRIES - 1));
    assign scanning  = (r_state == S_LOOK) || (r_state == S_HIT) ||
                       (r_state == S_EVICT) || (r_state == S_INS);

    // add for fit check and insert, saturating subtract for eviction
    assign alu_sub   = (r_state == S_EVICT);
    assign alu_op    = alu_sub ? rd_size : r_size;
    assign alu_res   = alu_sub ? ({1'b0, r_bytes} - {1'b0, alu_op})
                               : ({1'b0, r_bytes} + {1'b0, alu_op});
    assign over_cap  = alu_res > {1'b0, r_cap};
    assign size_fits = r_size <= r_cap;
    assign lru_age   = AGE_W'(r_count - 1'b1);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_TW'({r_o_bytes, r_o_evicted, r_o_stored, r_o_hit});

    // sequencer: next state, slot updates and result hand-off
    always_comb begin
        n_state     = r_state;
        n_ra        = r_ra;
        n_dv        = 1'b0;
        n_pi        = r_pi;
        n_valid     = r_valid;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_cap       = r_cap;
        n_ovalid    = r_ovalid;
        n_key       = r_key;
        n_size      = r_size;
        n_hidx      = r_hidx;
        n_hage      = r_hage;
        n_evicted   = r_evicted;
        n_hit       = r_hit;
        n_stored    = r_stored;
        n_last      = r_last;
        n_placed    = r_placed;
        n_o_hit     = r_o_hit;
        n_o_stored  = r_o_stored;
        n_o_evicted = r_o_evicted;
        n_o_bytes   = r_o_bytes;
        ram_wen     = 1'b0;
        ram_wdata   = ram_rdata;
        scan_start  = 1'b0;

        if (i_cfg_wen) begin
            n_cap = i_cfg_wdata;
        end
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        // walk the slots one per cycle; slot data returns through the registered RAM read port
        if (scanning && (r_ra < (IDX_W+1)'(ENTRIES))) begin
            n_ra = r_ra + 1'b1;
            n_dv = 1'b1;
            n_pi = r_ra[IDX_W-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_key      = i_s_tdata[KEY_BITS-1:0];
                    n_size     = i_s_tdata[KEY_BITS +: SIZE_BITS];
                    n_evicted  = '0;
                    n_hit      = 1'b0;
                    n_stored   = 1'b0;
                    n_state    = S_LOOK;
                    scan_start = 1'b1;
                end
            end
            S_LOOK: begin
                if (r_dv && rd_vld && (rd_key == r_key)) begin
                    n_hidx     = r_pi;
                    n_hage     = rd_age;
                    n_state    = S_HIT;
                    scan_start = 1'b1;
                end else if (pass_last) begin
                    n_state = S_CHK;
                end
            end
            S_HIT: begin
                // younger entries age by one, the hit entry becomes newest
                if (r_dv) begin
                    ram_wen = 1'b1;
                    if (r_pi == r_hidx) begin
                        ram_wdata = {AGE_W'(0), rd_size, rd_key};
                    end else if (rd_vld && (rd_age < r_hage)) begin
                        ram_wdata = {AGE_W'(rd_age + 1'b1), rd_size, rd_key};
                    end
                end
                if (pass_last) begin
                    n_hit    = 1'b1;
                    n_stored = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_CHK: begin
                if (over_cap && (r_count != '0)) begin
                    n_last     = 1'b0;
                    n_state    = S_EVICT;
                    scan_start = 1'b1;
                end else if (size_fits) begin
                    n_placed   = 1'b0;
                    scan_start = 1'b1;
                    if (r_count == (IDX_W+1)'(ENTRIES)) begin
                        n_last  = 1'b1;
                        n_state = S_EVICT;
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_stored = 1'b0;
                    n_state  = S_DONE;
                end
            end
            S_EVICT: begin
                // the LRU entry is the valid slot with age count-1
                if ((r_dv && rd_vld && (rd_age == lru_age)) || pass_last) begin
                    if (r_dv && rd_vld && (rd_age == lru_age)) begin
                        n_valid[r_pi] = 1'b0;
                        n_bytes   = alu_res[SIZE_BITS] ? '0 : alu_res[SIZE_BITS-1:0];
                        n_count   = r_count - 1'b1;
                        n_evicted = r_evicted + 1'b1;
                    end
                    if (r_last) begin
                        n_placed   = 1'b0;
                        n_state    = S_INS;
                        scan_start = 1'b1;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_INS: begin
                // age every valid slot, fill the first free one
                if (r_dv) begin
                    if (rd_vld) begin
                        ram_wen   = 1'b1;
                        ram_wdata = {AGE_W'(rd_age + 1'b1), rd_size, rd_key};
                    end else if (!r_placed) begin
                        ram_wen       = 1'b1;
                        ram_wdata     = {AGE_W'(0), r_size, r_key};
                        n_valid[r_pi] = 1'b1;
                        n_placed      = 1'b1;
                        n_count       = r_count + 1'b1;
                        n_bytes       = alu_res[SIZE_BITS-1:0];
                    end
                end
                if (pass_last) begin
                    n_stored = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_o_hit     = r_hit;
                    n_o_stored  = r_stored;
                    n_o_evicted = r_evicted;
                    n_o_bytes   = r_bytes;
                    n_ovalid    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // every walk begins at slot zero with an empty read pipe
        if (scan_start) begin
            n_ra = '0;
            n_dv = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ra     <= '0;
            r_dv     <= 1'b0;
            r_pi     <= '0;
            r_valid  <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_cap    <= CAP_RESET[SIZE_BITS-1:0];
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ra     <= n_ra;
            r_dv     <= n_dv;
            r_pi     <= n_pi;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_cap    <= n_cap;
            r_ovalid <= n_ovalid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_size      <= n_size;
        r_hidx      <= n_hidx;
        r_hage      <= n_hage;
        r_evicted   <= n_evicted;
        r_hit       <= n_hit;
        r_stored    <= n_stored;
        r_last      <= n_last;
        r_placed    <= n_placed;
        r_o_hit     <= n_o_hit;
        r_o_stored  <= n_o_stored;
        r_o_evicted <= n_o_evicted;
        r_o_bytes   <= n_o_bytes;
    end

`ifndef SYNTHESIS
    // occupancy counter tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_count)
        else $error("slot count differs from valid bits");

    // a hit never evicts anything
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_hit) |-> (r_o_evicted == '0 && r_o_stored))
        else $error("hit result reports evictions or not stored");

    // an insert keeps the used bytes within capacity
    a_insert_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && r_dv && !rd_vld && !r_placed) |=> (r_bytes <= r_cap))
        else $error("insert exceeded capacity");

    // the insert walk always finds a free slot
    a_insert_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && pass_last) |=> (r_placed && r_count != '0))
        else $error("insert walk found no free slot");

    // an empty table holds no bytes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_bytes == '0))
        else $error("empty table with bytes in use");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/swlc_ram.sv
`default_nettype none

module swlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wen,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
